// ----- rtl/idd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idd_pkg: shared types and constants of the int4 group dequant dot block
// Field widths, fixed-point positions and the structs that pass between the
// lanes, the merge stage and the group counter reducer.
// ----------------------------------------------------------------------------
package idd_pkg;

    localparam int ACCUM_BITS_DEF = 48;

    localparam int ACT_W      = 16;
    localparam int SCALE_W    = 16;
    localparam int ZERO_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int NIB_W      = 4;
    localparam int DOT_W      = 32;

    // group size register and position counter
    localparam int GS_W       = 9;
    localparam logic [GS_W-1:0] GS_RESET = 9'd32;
    localparam int CNT_W      = $clog2(GS_W + 1);

    // dequant: ((q << 8) - zero) * scale >>> 8
    localparam int ZP_SHIFT   = 8;
    localparam int SCALE_SHIFT = 8;
    localparam int DIFF_W     = ZERO_W + 1;
    localparam int PROD1_W    = DIFF_W + SCALE_W;
    localparam int WGT_W      = PROD1_W - SCALE_SHIFT;
    localparam int PROD_W     = WGT_W + ACT_W;

    // Q.24 sum down to Q.12 result
    localparam int FRAC_BITS  = 12;
    localparam logic signed [DOT_W-1:0] DOT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DOT_W-1:0] DOT_MIN = 32'sh8000_0000;

    // one item leaving the lanes toward the merge stage
    typedef struct packed {
        logic fire;
        logic last;
    } idd_ctl_t;

    // status of the group position reducer
    typedef struct packed {
        logic            busy;
        logic            done;
        logic [GS_W-1:0] rem;
    } idd_red_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/idd_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idd_lane: one dequant and multiply lane
// Stage 1 forms (q*256 - zero) * scale, stage 2 takes the Q.12 weight and
// multiplies it by the activation.
// ----------------------------------------------------------------------------
module idd_lane (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic        [idd_pkg::NIB_W-1:0]    nibble,
    input  wire logic signed [idd_pkg::ACT_W-1:0]    act,
    input  wire logic signed [idd_pkg::SCALE_W-1:0]  scale,
    input  wire logic signed [idd_pkg::ZERO_W-1:0]   zero,
    output logic signed      [idd_pkg::PROD_W-1:0]   prod
);
    import idd_pkg::*;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD1_W-1:0] prod1_next;
    logic signed [PROD1_W-1:0] prod1_reg;
    logic signed [ACT_W-1:0]   act_reg;
    logic signed [WGT_W-1:0]   wgt;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_reg;

    assign diff = $signed({{(DIFF_W - NIB_W - ZP_SHIFT){nibble[NIB_W-1]}},
                           nibble, {ZP_SHIFT{1'b0}}}) - DIFF_W'(zero);
    assign prod1_next = diff * scale;

    // floor shift: drop the low bits of the signed product
    assign wgt       = $signed(prod1_reg[PROD1_W-1:SCALE_SHIFT]);
    assign prod_next = wgt * act_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg <= prod1_next;
            act_reg   <= act;
            prod_reg  <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

// ----- rtl/idd_pos_reduce.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idd_pos_reduce: group position remainder unit
// Restoring remainder, one dividend bit per cycle, used to bring the group
// position below a newly written group size.
// ----------------------------------------------------------------------------
module idd_pos_reduce (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [idd_pkg::GS_W-1:0]    dividend,
    input  wire logic [idd_pkg::GS_W-1:0]    divisor,
    output idd_pkg::idd_red_rsp_t            rsp
);
    import idd_pkg::*;

    localparam logic [CNT_W-1:0] STEPS    = CNT_W'(GS_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [GS_W-1:0]  dvd_reg, dvd_next;
    logic [GS_W-1:0]  dsr_reg, dsr_next;
    logic [GS_W-1:0]  rem_reg, rem_next;
    logic [GS_W:0]    trial;

    assign trial = {rem_reg, dvd_reg[GS_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEPS;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // keep the partial remainder below the divisor
            if (trial >= {1'b0, dsr_reg})
                rem_next = GS_W'(trial - {1'b0, dsr_reg});
            else
                rem_next = trial[GS_W-1:0];
            dvd_next = {dvd_reg[GS_W-2:0], 1'b0};
            cnt_next = cnt_reg - LAST_CNT;
            if (cnt_reg == LAST_CNT)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

// ----- rtl/idd_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idd_merge: accumulate and result stage
// Adds both lane products into the accumulator, tracks the group position
// and forms the saturated result into the output register on the last item.
// ----------------------------------------------------------------------------
module idd_merge #(
    parameter int ACCUM_BITS = idd_pkg::ACCUM_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire idd_pkg::idd_ctl_t                   ctl,
    input  wire logic signed [idd_pkg::PROD_W-1:0]   p0,
    input  wire logic signed [idd_pkg::PROD_W-1:0]   p1,
    input  wire logic        [idd_pkg::GS_W-1:0]     gs,
    input  wire idd_pkg::idd_red_rsp_t               red,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic signed      [idd_pkg::DOT_W-1:0]    dot_value,
    output logic                                     length_error,
    output logic             [idd_pkg::GS_W-1:0]     pos
);
    import idd_pkg::*;

    localparam int SH_W = ACCUM_BITS - FRAC_BITS;
    localparam logic [GS_W:0] POS_STEP = (GS_W + 1)'(2);

    logic signed [ACCUM_BITS-1:0] acc_reg, acc_next, acc_sum;
    logic        [GS_W-1:0]       pos_reg, pos_next, pos_adv;
    logic        [GS_W:0]         step0, step1, step2;
    logic                         err;
    logic signed [SH_W-1:0]       sh;
    logic signed [DOT_W-1:0]      sat;
    logic                         out_valid_reg, out_valid_next;
    logic signed [DOT_W-1:0]      dot_reg;
    logic                         err_reg;

    assign acc_sum = acc_reg + ACCUM_BITS'(p0) + ACCUM_BITS'(p1);
    assign sh      = $signed(acc_sum[ACCUM_BITS-1:FRAC_BITS]);

    generate
        if (SH_W > DOT_W)
        begin : g_sat
            logic hi_ones, hi_zeros;
            assign hi_ones  = &sh[SH_W-1:DOT_W-1];
            assign hi_zeros = ~|sh[SH_W-1:DOT_W-1];
            assign sat = (hi_ones || hi_zeros) ? $signed(sh[DOT_W-1:0])
                       : (sh[SH_W-1] ? DOT_MIN : DOT_MAX);
        end
        else
        begin : g_ext
            assign sat = DOT_W'(sh);
        end
    endgenerate

    // position stays below gs, so two conditional subtracts cover gs of one
    always_comb
    begin
        step0 = {1'b0, pos_reg} + POS_STEP;
        step1 = (step0 >= {1'b0, gs}) ? step0 - {1'b0, gs} : step0;
        step2 = (step1 >= {1'b0, gs}) ? step1 - {1'b0, gs} : step1;
        pos_adv = (gs == '0) ? pos_reg : step2[GS_W-1:0];
        err = (gs == '0) || (pos_adv != '0);
    end

    always_comb
    begin
        acc_next = acc_reg;
        pos_next = pos_reg;
        if (red.done)
            pos_next = red.rem;
        if (ctl.fire)
        begin
            acc_next = ctl.last ? '0 : acc_sum;
            pos_next = ctl.last ? '0 : pos_adv;
        end
        out_valid_next = out_valid_reg && !out_ready;
        if (ctl.fire && ctl.last)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fire && ctl.last)
        begin
            dot_reg <= err ? '0 : sat;
            err_reg <= err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dot_value    = dot_reg;
    assign length_error = err_reg;
    assign pos          = pos_reg;

endmodule
`default_nettype wire

// ----- rtl/int4_group_dequant_dot.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int4_group_dequant_dot: int4 group-quantized dot product, one output element
// Two lanes dequantize the nibbles of a packed weight byte and multiply them
// by their activations; a merge stage accumulates and emits the result.
// ----------------------------------------------------------------------------
// Usage: send one transfer per packed weight byte, with its two Q4.12
// activations and the scale and zero point of its group, and mark the final
// byte of the run with last. The block accepts one item per clock cycle while
// in_ready is high and loads the Q20.12 sum, saturated to 32 bits, into the
// output register through the dequant multiply, activation multiply and
// accumulate stages. The pipeline holds only while a finished result waits
// in the output register and another last item has reached the accumulate
// stage. A run whose weight count is not a multiple of the group size
// returns 0 with length_error set. Writing a nonzero group size starts a
// renormalization of the group position counter (nine remainder steps and a
// load), during which in_ready and cfg_ready stay low. Write the group size
// only with the block idle. The accumulator wraps at ACCUM_BITS bits.
// ----------------------------------------------------------------------------
module int4_group_dequant_dot #(
    parameter int ACCUM_BITS = idd_pkg::ACCUM_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // group size register write
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic        [idd_pkg::GS_W-1:0]     cfg_data,
    // input items
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [idd_pkg::ACT_W-1:0]    act_low,
    input  wire logic signed [idd_pkg::ACT_W-1:0]    act_high,
    input  wire logic        [idd_pkg::BYTE_W-1:0]   weight_byte,
    input  wire logic signed [idd_pkg::SCALE_W-1:0]  group_scale,
    input  wire logic signed [idd_pkg::ZERO_W-1:0]   group_zero,
    input  wire logic                                last,
    // results
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed      [idd_pkg::DOT_W-1:0]    dot_value,
    output logic                                     length_error
);
    import idd_pkg::*;

    logic               [GS_W-1:0]   gs_reg;
    logic                            cfg_xfer;
    logic                            in_xfer;
    logic                            adv;
    logic                            v1_reg, v2_reg;
    logic                            last1_reg, last2_reg;
    logic signed        [PROD_W-1:0] p0, p1;
    logic               [GS_W-1:0]   pos;
    idd_ctl_t                        ctl;
    idd_red_rsp_t                    red;

    // Hold the whole pipe only when a last item needs the output register
    // and the previous result has not been taken.
    assign adv = !(v2_reg && last2_reg && out_valid && !out_ready);

    // No item transfer while the group counter is being renormalized or a
    // register write is pending.
    assign in_ready  = adv && !red.busy && !red.done && !cfg_valid;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = !red.busy && !red.done;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_reg <= GS_RESET;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (cfg_xfer)
                gs_reg <= cfg_data;
            if (adv)
            begin
                v1_reg <= in_xfer;
                v2_reg <= v1_reg;
            end
        end
    end

    // Advance the last flags alongside the lane products.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last1_reg <= last;
            last2_reg <= last1_reg;
        end
    end

    // Even position: low nibble. Odd position: high nibble.
    idd_lane u_lane_lo (
        .clk    (clk),
        .en     (adv),
        .nibble (weight_byte[NIB_W-1:0]),
        .act    (act_low),
        .scale  (group_scale),
        .zero   (group_zero),
        .prod   (p0)
    );

    idd_lane u_lane_hi (
        .clk    (clk),
        .en     (adv),
        .nibble (weight_byte[BYTE_W-1:NIB_W]),
        .act    (act_high),
        .scale  (group_scale),
        .zero   (group_zero),
        .prod   (p1)
    );

    // Reduce the group position modulo a newly written nonzero size.
    idd_pos_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cfg_xfer && (cfg_data != '0)),
        .dividend (pos),
        .divisor  (cfg_data),
        .rsp      (red)
    );

    assign ctl.fire = adv && v2_reg;
    assign ctl.last = last2_reg;

    idd_merge #(
        .ACCUM_BITS (ACCUM_BITS)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .p0           (p0),
        .p1           (p1),
        .gs           (gs_reg),
        .red          (red),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .dot_value    (dot_value),
        .length_error (length_error),
        .pos          (pos)
    );

    // A length error always carries a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && length_error |-> dot_value == '0)
        else $error("length error result with nonzero value");

    // No item enters while the group counter is renormalized.
    a_reduce_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        red.busy |-> !in_ready && !cfg_ready)
        else $error("transfer allowed during group counter reduction");

    // Group position stays below a nonzero group size outside reduction.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        !red.busy && !red.done && gs_reg != '0 |-> pos < gs_reg)
        else $error("group position out of range");

    // A waiting last item with a full output register stalls intake.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && last2_reg && out_valid && !out_ready |-> !in_ready)
        else $error("intake not held while result waits");

endmodule
`default_nettype wire
